// File: hw/rtl/cabr_pkg.sv
package cabr_pkg;

   localparam int MAX_HEIGHT = 256;
   localparam int MAX_WIDTH  = 256;

   localparam int ROW_AW = $clog2(MAX_HEIGHT);
   localparam int COL_AW = $clog2(MAX_WIDTH);
   localparam int ADDR_W = ROW_AW + COL_AW;

   localparam int CNT_W      = 8;
   localparam int LIM_W      = 9;
   localparam int CH_MAX     = 255;
   localparam int DATA_W     = 32;
   localparam int ACT_W      = 31;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 9;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);
   localparam int PEND_W     = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_CHANNELS_IN  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNELS_OUT = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_HEIGHT = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_WIDTH  = CSR_IDX_W'(3);

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic              first;
      logic              emit;
      logic [CNT_W-1:0]  out_channel;
      logic [CNT_W-1:0]  pixel_row;
      logic [CNT_W-1:0]  pixel_col;
      logic              run_last;
   } tag_type;

   typedef struct packed {
      logic [ACT_W-1:0] activation;
      logic [CNT_W-1:0] out_channel;
      logic [CNT_W-1:0] pixel_row;
      logic [CNT_W-1:0] pixel_col;
      logic             run_last;
   } result_type;

endpackage

// File: hw/rtl/channel_accumulate_bias_relu.sv
// Accumulates per-pixel partial sums over input channels in a 64K x 32 plane store
// and emits bias-added, ReLU-clamped pixels. One request is accepted every clock while
// the four-entry result queue has room for it; the request that completes a pixel
// passes the store's read register, the accumulate-and-write register and the
// bias-and-clamp step into that queue, whose head drives rsp_valid. Each request costs one
// read and one write of the store, on separate ports; a pixel that is written and read
// by back-to-back requests takes the forwarded sum. The first input channel overwrites
// its entry, so the store needs no clearing after reset. The user must write registers
// through the csr_ port only while no request is in flight; the block does not enforce it.
module channel_accumulate_bias_relu (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic signed [31:0]               req_partial_sum,
   input  logic signed [31:0]               req_bias,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [30:0]                      rsp_activation,
   output logic [7:0]                       rsp_out_channel,
   output logic [7:0]                       rsp_pixel_row,
   output logic [7:0]                       rsp_pixel_col,
   output logic                             rsp_run_last,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [cabr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [cabr_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   logic                             take;
   cabr_pkg::tag_type                tag;
   logic                             res_valid;
   cabr_pkg::result_type             res, head;
   logic [cabr_pkg::PEND_W-1:0]      pend;
   logic [cabr_pkg::FIFO_CW-1:0]     fifo_count;
   logic [cabr_pkg::FIFO_CW:0]       reserved;

   // in-flight results hold a queue slot before they arrive
   assign reserved  = (cabr_pkg::FIFO_CW+1)'(fifo_count) + (cabr_pkg::FIFO_CW+1)'(pend);
   assign req_stall = reserved >= (cabr_pkg::FIFO_CW+1)'(cabr_pkg::FIFO_DEPTH);
   assign take      = req_valid && !req_stall;

   cabr_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .advance   (take),
      .tag       (tag)
   );

   cabr_accum u_accum (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .tag_in    (tag),
      .psum_in   (req_partial_sum),
      .bias_in   (req_bias),
      .res_valid (res_valid),
      .res       (res),
      .pend      (pend)
   );

   cabr_out_fifo u_out_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (res_valid),
      .push_data  (res),
      .pop        (!rsp_stall),
      .head_valid (rsp_valid),
      .head       (head),
      .count      (fifo_count)
   );

   assign rsp_activation  = head.activation;
   assign rsp_out_channel = head.out_channel;
   assign rsp_pixel_row   = head.pixel_row;
   assign rsp_pixel_col   = head.pixel_col;
   assign rsp_run_last    = head.run_last;

endmodule

// File: hw/rtl/cabr_seq.sv
module cabr_seq (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [cabr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [cabr_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                             advance,
   output cabr_pkg::tag_type                tag
);

   logic [cabr_pkg::CNT_W-1:0] ch_in_ff, ch_out_ff;
   logic [cabr_pkg::LIM_W-1:0] height_ff, width_ff;

   logic [cabr_pkg::CNT_W-1:0] in_cnt_ff, out_cnt_ff, row_ff, col_ff;
   logic [cabr_pkg::CNT_W-1:0] in_cnt_in, out_cnt_in, row_in, col_in;

   logic [cabr_pkg::LIM_W-1:0] lim_in, lim_out, lim_h, lim_w;
   logic last_in, last_out, last_row, last_col;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ch_in_ff  <= cabr_pkg::CNT_W'(1);
         ch_out_ff <= cabr_pkg::CNT_W'(1);
         height_ff <= cabr_pkg::LIM_W'(1);
         width_ff  <= cabr_pkg::LIM_W'(1);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            cabr_pkg::CSR_CHANNELS_IN:  ch_in_ff  <= csr_wdata[cabr_pkg::CNT_W-1:0];
            cabr_pkg::CSR_CHANNELS_OUT: ch_out_ff <= csr_wdata[cabr_pkg::CNT_W-1:0];
            cabr_pkg::CSR_PLANE_HEIGHT: height_ff <= csr_wdata;
            cabr_pkg::CSR_PLANE_WIDTH:  width_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // zero acts as one, oversized plane saturates
   always_comb begin
      lim_in  = (ch_in_ff == '0) ? cabr_pkg::LIM_W'(1) : cabr_pkg::LIM_W'(ch_in_ff);
      lim_out = (ch_out_ff == '0) ? cabr_pkg::LIM_W'(1) : cabr_pkg::LIM_W'(ch_out_ff);
      priority if (height_ff == '0)
         lim_h = cabr_pkg::LIM_W'(1);
      else if (height_ff > cabr_pkg::LIM_W'(cabr_pkg::MAX_HEIGHT))
         lim_h = cabr_pkg::LIM_W'(cabr_pkg::MAX_HEIGHT);
      else
         lim_h = height_ff;
      priority if (width_ff == '0)
         lim_w = cabr_pkg::LIM_W'(1);
      else if (width_ff > cabr_pkg::LIM_W'(cabr_pkg::MAX_WIDTH))
         lim_w = cabr_pkg::LIM_W'(cabr_pkg::MAX_WIDTH);
      else
         lim_w = width_ff;
   end

   assign last_in  = (cabr_pkg::LIM_W'(in_cnt_ff) + cabr_pkg::LIM_W'(1)) >= lim_in;
   assign last_out = (cabr_pkg::LIM_W'(out_cnt_ff) + cabr_pkg::LIM_W'(1)) >= lim_out;
   assign last_row = (cabr_pkg::LIM_W'(row_ff) + cabr_pkg::LIM_W'(1)) >= lim_h;
   assign last_col = (cabr_pkg::LIM_W'(col_ff) + cabr_pkg::LIM_W'(1)) >= lim_w;

   always_comb begin
      tag.addr        = {row_ff[cabr_pkg::ROW_AW-1:0], col_ff[cabr_pkg::COL_AW-1:0]};
      tag.first       = (in_cnt_ff == '0);
      tag.emit        = last_in;
      tag.out_channel = out_cnt_ff;
      tag.pixel_row   = row_ff;
      tag.pixel_col   = col_ff;
      tag.run_last    = last_out && last_row && last_col;
   end

   // column fastest, then row, then input channel, then output channel
   always_comb begin
      in_cnt_in  = in_cnt_ff;
      out_cnt_in = out_cnt_ff;
      row_in     = row_ff;
      col_in     = col_ff;
      if (!last_col) begin
         col_in = col_ff + cabr_pkg::CNT_W'(1);
      end else begin
         col_in = '0;
         if (!last_row) begin
            row_in = row_ff + cabr_pkg::CNT_W'(1);
         end else begin
            row_in = '0;
            if (!last_in) begin
               in_cnt_in = in_cnt_ff + cabr_pkg::CNT_W'(1);
            end else begin
               in_cnt_in  = '0;
               out_cnt_in = last_out ? '0 : out_cnt_ff + cabr_pkg::CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_cnt_ff  <= '0;
         out_cnt_ff <= '0;
         row_ff     <= '0;
         col_ff     <= '0;
      end else if (advance) begin
         in_cnt_ff  <= in_cnt_in;
         out_cnt_ff <= out_cnt_in;
         row_ff     <= row_in;
         col_ff     <= col_in;
      end
   end

endmodule

// File: hw/rtl/cabr_accum.sv
module cabr_accum (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            take,
   input  cabr_pkg::tag_type               tag_in,
   input  logic [cabr_pkg::DATA_W-1:0]     psum_in,
   input  logic [cabr_pkg::DATA_W-1:0]     bias_in,
   output logic                            res_valid,
   output cabr_pkg::result_type            res,
   output logic [cabr_pkg::PEND_W-1:0]     pend
);

   localparam int DEPTH = 1 << cabr_pkg::ADDR_W;

   logic [cabr_pkg::DATA_W-1:0] plane_mem [DEPTH];

   // read stage
   logic                        v1_ff;
   cabr_pkg::tag_type           tag1_ff;
   logic [cabr_pkg::DATA_W-1:0] psum1_ff, bias1_ff, rdata1_ff, fwd1_ff;
   logic                        haz1_ff;
   logic [cabr_pkg::DATA_W-1:0] base1, sum1;

   // bias and clamp stage
   logic                        v2_ff;
   cabr_pkg::tag_type           tag2_ff;
   logic [cabr_pkg::DATA_W-1:0] sum2_ff, bias2_ff, total2;

   // the write of the item ahead lands on the same edge as this read
   assign base1 = haz1_ff ? fwd1_ff : rdata1_ff;
   assign sum1  = tag1_ff.first ? psum1_ff : base1 + psum1_ff;

   always_ff @(posedge clock) begin
      if (take) begin
         rdata1_ff <= plane_mem[tag_in.addr];
      end
      if (v1_ff) begin
         plane_mem[tag1_ff.addr] <= sum1;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         tag1_ff  <= tag_in;
         psum1_ff <= psum_in;
         bias1_ff <= bias_in;
         haz1_ff  <= v1_ff && (tag1_ff.addr == tag_in.addr);
         fwd1_ff  <= sum1;
      end
      tag2_ff  <= tag1_ff;
      sum2_ff  <= sum1;
      bias2_ff <= bias1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= take;
         v2_ff <= v1_ff && tag1_ff.emit;
      end
   end

   assign total2 = sum2_ff + bias2_ff;

   always_comb begin
      res.activation  = total2[cabr_pkg::DATA_W-1] ? '0 : total2[cabr_pkg::ACT_W-1:0];
      res.out_channel = tag2_ff.out_channel;
      res.pixel_row   = tag2_ff.pixel_row;
      res.pixel_col   = tag2_ff.pixel_col;
      res.run_last    = tag2_ff.run_last;
   end

   assign res_valid = v2_ff;
   assign pend = cabr_pkg::PEND_W'(v1_ff && tag1_ff.emit) + cabr_pkg::PEND_W'(v2_ff);

endmodule

// File: hw/rtl/cabr_out_fifo.sv
module cabr_out_fifo (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   input  cabr_pkg::result_type             push_data,
   input  logic                             pop,
   output logic                             head_valid,
   output cabr_pkg::result_type             head,
   output logic [cabr_pkg::FIFO_CW-1:0]     count
);

   cabr_pkg::result_type              entry_ff [cabr_pkg::FIFO_DEPTH];
   logic [cabr_pkg::FIFO_AW-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [cabr_pkg::FIFO_CW-1:0]      count_ff, count_in;
   logic                              do_pop;

   assign do_pop = pop && (count_ff != '0);

   always_comb begin
      count_in = count_ff;
      unique case ({push, do_pop})
         2'b10:   count_in = count_ff + cabr_pkg::FIFO_CW'(1);
         2'b01:   count_in = count_ff - cabr_pkg::FIFO_CW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + cabr_pkg::FIFO_AW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + cabr_pkg::FIFO_AW'(1);
         end
         count_ff <= count_in;
      end
   end

   assign head_valid = (count_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];
   assign count      = count_ff;

endmodule

// File: hw/rtl/cabr_checker.sv
module cabr_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [30:0] rsp_activation,
   input logic [7:0]  rsp_out_channel,
   input logic [7:0]  rsp_pixel_row,
   input logic [7:0]  rsp_pixel_col,
   input logic        rsp_run_last
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_activation)
         && $stable(rsp_out_channel) && $stable(rsp_pixel_row)
         && $stable(rsp_pixel_col) && $stable(rsp_run_last))
      else $error("stalled response changed");

   // nothing can come out of the pipeline directly after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid ##1 !rsp_valid)
      else $error("response too soon after reset");

   // output channel index never reaches 255
   a_channel_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_out_channel != 8'hFF)
      else $error("output channel out of range");

endmodule

bind channel_accumulate_bias_relu cabr_checker u_cabr_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_activation  (rsp_activation),
   .rsp_out_channel (rsp_out_channel),
   .rsp_pixel_row   (rsp_pixel_row),
   .rsp_pixel_col   (rsp_pixel_col),
   .rsp_run_last    (rsp_run_last)
);

// File: sim/channel_accumulate_bias_relu_tb.sv
module channel_accumulate_bias_relu_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cabr_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 8'hFF;
   localparam int RANDOM_ITEMS  = 1900;
   localparam int SETTLE_CYCLES = 8;
   localparam int QUIET_LIMIT   = 2000;
   localparam logic [CSR_IDX_W-1:0] REG_LIST [4] =
      '{CSR_CHANNELS_IN, CSR_CHANNELS_OUT, CSR_PLANE_HEIGHT, CSR_PLANE_WIDTH};

   class pixel_predictor;
      logic [31:0]     running_sum [MAX_HEIGHT*MAX_WIDTH];
      logic [8:0]      ch_in, ch_out, height, width;
      logic [7:0]      in_ch, out_ch, row, col;
      result_type      pending_pixels [$];
      int              mismatches;

      function new();
         ch_in = 1;
         ch_out = 1;
         height = 1;
         width = 1;
         in_ch = 0;
         out_ch = 0;
         row = 0;
         col = 0;
         mismatches = 0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_CHANNELS_IN:  ch_in = {1'b0, data[7:0]};
            CSR_CHANNELS_OUT: ch_out = {1'b0, data[7:0]};
            CSR_PLANE_HEIGHT: height = data;
            CSR_PLANE_WIDTH:  width = data;
            default: ;
         endcase
      endfunction

      function int limit_of(logic [CSR_IDX_W-1:0] idx);
         int raw;
         int ceiling;
         case (idx)
            CSR_CHANNELS_IN: begin
               raw = int'(ch_in);
               ceiling = CH_MAX;
            end
            CSR_CHANNELS_OUT: begin
               raw = int'(ch_out);
               ceiling = CH_MAX;
            end
            CSR_PLANE_HEIGHT: begin
               raw = int'(height);
               ceiling = MAX_HEIGHT;
            end
            default: begin
               raw = int'(width);
               ceiling = MAX_WIDTH;
            end
         endcase
         if (raw == 0) return 1;
         if (raw > ceiling) return ceiling;
         return raw;
      endfunction

      function bit at_run_start();
         return in_ch == 0 && out_ch == 0 && row == 0 && col == 0;
      endfunction

      function int pending();
         return pending_pixels.size();
      endfunction

      function void accumulate(logic [31:0] psum, logic [31:0] bias);
         logic [15:0] addr;
         logic [31:0] total;
         logic [31:0] biased;
         bit          last_in, last_out, last_row, last_col;
         result_type  pixel;
         last_in  = int'(in_ch) + 1 >= limit_of(CSR_CHANNELS_IN);
         last_out = int'(out_ch) + 1 >= limit_of(CSR_CHANNELS_OUT);
         last_row = int'(row) + 1 >= limit_of(CSR_PLANE_HEIGHT);
         last_col = int'(col) + 1 >= limit_of(CSR_PLANE_WIDTH);
         // 8-bit counters index a 256 x 256 store directly
         addr = {row, col};
         total = (in_ch == 0) ? psum : running_sum[addr] + psum;
         running_sum[addr] = total;
         if (last_in) begin
            biased = total + bias;
            if (biased[31]) biased = '0;
            pixel.activation  = biased[30:0];
            pixel.out_channel = out_ch;
            pixel.pixel_row   = row;
            pixel.pixel_col   = col;
            pixel.run_last    = last_out && last_row && last_col;
            pending_pixels.push_back(pixel);
         end
         if (!last_col) begin
            col++;
         end else begin
            col = 0;
            if (!last_row) begin
               row++;
            end else begin
               row = 0;
               if (!last_in) begin
                  in_ch++;
               end else begin
                  in_ch = 0;
                  out_ch = last_out ? 8'd0 : out_ch + 8'd1;
               end
            end
         end
      endfunction

      function void check_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
         end
      endfunction

      function void compare_pixel(result_type got);
         result_type want;
         if (pending_pixels.size() == 0) begin
            $error("unexpected pixel: channel %0d row %0d col %0d", got.out_channel,
                   got.pixel_row, got.pixel_col);
            mismatches++;
            return;
         end
         want = pending_pixels.pop_front();
         check_field("activation", 32'(want.activation), 32'(got.activation));
         check_field("out_channel", 32'(want.out_channel), 32'(got.out_channel));
         check_field("pixel_row", 32'(want.pixel_row), 32'(got.pixel_row));
         check_field("pixel_col", 32'(want.pixel_col), 32'(got.pixel_col));
         check_field("run_last", 32'(want.run_last), 32'(got.run_last));
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic signed [31:0]    req_partial_sum = '0;
   logic signed [31:0]    req_bias = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [30:0]           rsp_activation;
   logic [7:0]            rsp_out_channel;
   logic [7:0]            rsp_pixel_row;
   logic [7:0]            rsp_pixel_col;
   logic                  rsp_run_last;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   pixel_predictor predictor;
   bit             calm = 1'b0;
   int             quiet_cycles = 0;

   channel_accumulate_bias_relu dut (
      .clock,
      .reset,
      .req_valid,
      .req_stall,
      .req_partial_sum,
      .req_bias,
      .rsp_valid,
      .rsp_stall,
      .rsp_activation,
      .rsp_out_channel,
      .rsp_pixel_row,
      .rsp_pixel_col,
      .rsp_run_last,
      .csr_valid,
      .csr_ready,
      .csr_index,
      .csr_wdata
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      result_type observed;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            observed.activation  = rsp_activation;
            observed.out_channel = rsp_out_channel;
            observed.pixel_row   = rsp_pixel_row;
            observed.pixel_col   = rsp_pixel_col;
            observed.run_last    = rsp_run_last;
            predictor.compare_pixel(observed);
         end
         rsp_stall <= !calm && $urandom_range(99) < 8;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("channel_accumulate_bias_relu regression: fail");
            $finish;
         end
      end
   end

   // caller lowers csr_valid once its writes are done
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      predictor.write_register(idx, data);
   endtask

   task automatic send_request(input logic [31:0] psum, input logic [31:0] bias);
      while (!calm && $urandom_range(99) < 8) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_partial_sum <= psum;
      req_bias <= bias;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predictor.accumulate(psum, bias);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (predictor.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_value();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 10) begin
         case ($urandom_range(3))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
         endcase
      end
      if (r < 35) return $urandom();
      // mostly values near zero so both sides of the clamp show up
      return 32'(int'($urandom_range(0, (1 << 28) - 1)) - (1 << 27));
   endfunction

   function automatic logic [CSR_DATA_W-1:0] fresh_value(logic [CSR_IDX_W-1:0] idx);
      int unsigned r;
      r = $urandom_range(99);
      if (idx == CSR_CHANNELS_IN || idx == CSR_CHANNELS_OUT) begin
         if (r < 5) return '0;
         if (r < 8) return 9'h1FF;
         return CSR_DATA_W'($urandom_range(1, 4));
      end
      if (r < 4) return '0;
      if (r < 7) return CSR_DATA_W'($urandom_range(257, 511));
      return CSR_DATA_W'($urandom_range(1, 6));
   endfunction

   // growing a limit mid-run could read sums never written, so only shrink then
   task automatic reconfigure();
      bit fresh;
      fresh = predictor.at_run_start();
      foreach (REG_LIST[i]) begin
         if (fresh && $urandom_range(99) < 70)
            write_csr(REG_LIST[i], fresh_value(REG_LIST[i]));
         else if (!fresh && $urandom_range(1) == 1)
            write_csr(REG_LIST[i],
                      CSR_DATA_W'($urandom_range(predictor.limit_of(REG_LIST[i]))));
      end
      csr_valid <= 1'b0;
   endtask

   initial begin
      int  sent;
      int  burst;
      bit  stop_at_wrap;
      predictor = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // two input channels, two output planes of one row by two columns
      write_csr(CSR_CHANNELS_IN, 9'd2);
      write_csr(CSR_CHANNELS_OUT, 9'd2);
      write_csr(CSR_PLANE_HEIGHT, 9'd1);
      write_csr(CSR_PLANE_WIDTH, 9'd2);
      write_csr(CSR_UNUSED, 9'h1FF);
      csr_valid <= 1'b0;
      send_request(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_request(32'h8000_0000, 32'h7FFF_FFFF);
      send_request(32'h0000_0001, 32'h7FFF_FFFF);
      send_request(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_request(32'h0000_0000, 32'h0000_0000);
      send_request(32'hFFFF_FFFF, 32'h8000_0000);
      send_request(32'h0000_0000, 32'h0000_0000);
      send_request(32'h0000_0001, 32'h8000_0000);
      wait_for_results();

      // all registers zero behave as one
      foreach (REG_LIST[i]) write_csr(REG_LIST[i], 9'd0);
      csr_valid <= 1'b0;
      send_request(32'h1234_5678, 32'h8000_0000);
      send_request(32'hFFFF_FFFB, 32'h0000_0010);
      send_request(32'h0000_0000, 32'h0000_0000);
      wait_for_results();

      // grow the limits, then shrink three of them below the counters mid-run
      write_csr(CSR_CHANNELS_IN, 9'd1);
      write_csr(CSR_CHANNELS_OUT, 9'd3);
      write_csr(CSR_PLANE_HEIGHT, 9'd3);
      write_csr(CSR_PLANE_WIDTH, 9'd2);
      csr_valid <= 1'b0;
      repeat (11) send_request(pick_value(), pick_value());
      wait_for_results();
      write_csr(CSR_CHANNELS_OUT, 9'd1);
      write_csr(CSR_PLANE_HEIGHT, 9'd1);
      write_csr(CSR_PLANE_WIDTH, 9'd1);
      csr_valid <= 1'b0;
      send_request(pick_value(), pick_value());
      wait_for_results();

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         wait_for_results();
         reconfigure();
         burst = $urandom_range(10, 200);
         stop_at_wrap = $urandom_range(1);
         for (int i = 0; i < burst; i++) begin
            calm = sent >= 600 && sent < 900;
            send_request(pick_value(), pick_value());
            sent++;
            if (stop_at_wrap && predictor.at_run_start()) break;
         end
      end
      calm = 1'b0;
      wait_for_results();

      if (predictor.mismatches == 0 && predictor.pending() == 0)
         $display("channel_accumulate_bias_relu regression: pass");
      else
         $display("channel_accumulate_bias_relu regression: fail");
      $finish;
   end

endmodule
